/* src/sbpio_pkg.sv */
// ----------------------------------------------------------------------------
// sbpio_pkg
// Shared types and constants of the two-port pad I/O block.
// ----------------------------------------------------------------------------
package sbpio_pkg;

	localparam int unsigned IN_TDATA_W  = 32;
	localparam int unsigned OUT_TDATA_W = 8;

	localparam logic [1:0] OP_READ    = 2'd0;
	localparam logic [1:0] OP_WRITE   = 2'd1;
	localparam logic [1:0] OP_TIMEOUT = 2'd2;

	localparam logic [3:0] W_VERSION = 4'd0;
	localparam logic [3:0] W_P1_DATA = 4'd1;
	localparam logic [3:0] W_P2_DATA = 4'd2;
	localparam logic [3:0] W_EX_DATA = 4'd3;
	localparam logic [3:0] W_P1_CTRL = 4'd4;
	localparam logic [3:0] W_P2_CTRL = 4'd5;
	localparam logic [3:0] W_EX_CTRL = 4'd6;

	localparam logic CFG_VERSION = 1'b0;
	localparam logic CFG_SIX_BTN = 1'b1;

	localparam logic [7:0] VERSION_RESET = 8'h80;
	localparam logic [7:0] EXP_READ      = 8'hFF;
	localparam logic [7:0] COUNT_MAX     = 8'hFF;
	localparam int unsigned TH_POS       = 6;

	typedef struct packed {
		logic [11:0] pad_buttons;
		logic [7:0]  write_data;
		logic [3:0]  reg_word;
		logic [1:0]  opcode;
	} item_t;

	typedef struct packed {
		logic [7:0]      version_byte;
		logic [1:0]      six_button_ports;
		logic [2:0][7:0] port_data;
		logic [2:0][7:0] port_ctrl;
		logic [1:0]      th_previous;
		logic [1:0][7:0] th_edge_count;
	} port_state_t;

endpackage

/* src/sbpio_state.sv */
// ----------------------------------------------------------------------------
// sbpio_state
// Configuration, data and control bytes, TH tracking and edge counters.
// ----------------------------------------------------------------------------
module sbpio_state
	import sbpio_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic        cfg_index,
	input  logic [7:0]  cfg_data,
	input  logic        upd_en,
	input  item_t       upd_item,
	output port_state_t st
);

	logic [7:0]      version_q;
	logic [1:0]      six_q;
	logic [2:0][7:0] data_q;
	logic [2:0][7:0] ctrl_q;
	logic [1:0]      th_prev_q;
	logic [1:0][7:0] count_q;
	logic            th_new;
	logic [1:0]      fall;

	assign th_new = upd_item.write_data[TH_POS];

	always_comb begin
		for (int p = 0; p < 2; p++) begin
			fall[p] = six_q[p] && th_prev_q[p] && !th_new && (count_q[p] != COUNT_MAX);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			version_q <= VERSION_RESET;
			six_q     <= '0;
			data_q    <= '0;
			ctrl_q    <= '0;
			th_prev_q <= '0;
			count_q   <= '0;
		end else begin
			if (cfg_we) begin
				unique case (cfg_index)
					CFG_VERSION: version_q <= cfg_data;
					CFG_SIX_BTN: six_q     <= cfg_data[1:0];
					default: ;
				endcase
			end
			if (upd_en) begin
				unique case (upd_item.opcode)
					OP_WRITE: begin
						unique case (upd_item.reg_word)
							W_P1_DATA: begin
								data_q[0]    <= upd_item.write_data;
								th_prev_q[0] <= th_new;
								if (fall[0]) count_q[0] <= count_q[0] + 8'd1;
							end
							W_P2_DATA: begin
								data_q[1]    <= upd_item.write_data;
								th_prev_q[1] <= th_new;
								if (fall[1]) count_q[1] <= count_q[1] + 8'd1;
							end
							W_EX_DATA: data_q[2] <= upd_item.write_data;
							W_P1_CTRL: ctrl_q[0] <= upd_item.write_data;
							W_P2_CTRL: ctrl_q[1] <= upd_item.write_data;
							W_EX_CTRL: ctrl_q[2] <= upd_item.write_data;
							default: ;
						endcase
					end
					OP_TIMEOUT: count_q <= '0;
					default: ;
				endcase
			end
		end
	end

	assign st.version_byte     = version_q;
	assign st.six_button_ports = six_q;
	assign st.port_data        = data_q;
	assign st.port_ctrl        = ctrl_q;
	assign st.th_previous      = th_prev_q;
	assign st.th_edge_count    = count_q;

`ifndef SYNTHESIS
	logic timeout_now;
	assign timeout_now = upd_en && (upd_item.opcode == OP_TIMEOUT);

	a_count_saturates: assert property (@(posedge clk) disable iff (!arst_n)
		(count_q[0] == COUNT_MAX) && !timeout_now |=> count_q[0] == COUNT_MAX)
		else $error("port one edge counter left saturation without timeout");

	a_three_btn_count_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!six_q[1] && !timeout_now |=> $stable(count_q[1]))
		else $error("port two edge counter moved in three-button mode");
`endif

endmodule

/* src/sbpio_read.sv */
// ----------------------------------------------------------------------------
// sbpio_read
// Read-data selection: version, TH-multiplexed pad bytes, control bytes.
// ----------------------------------------------------------------------------
module sbpio_read
	import sbpio_pkg::*;
(
	input  port_state_t st,
	input  item_t       item,
	output logic [7:0]  read_data
);

	function automatic logic [7:0] pad_byte(input logic th, input logic six,
		input logic [7:0] cnt, input logic [11:0] btn);
		logic [11:0] rel;
		logic [3:0]  low;
		logic [7:0]  v;
		rel = ~btn;
		if (th) begin
			if (six && cnt >= 8'd3) low = {rel[11], rel[8], rel[9], rel[10]};
			else                    low = {rel[3], rel[2], rel[1], rel[0]};
			v = {2'b01, rel[6], rel[5], low};
		end else begin
			if (six && cnt >= 8'd4)      low = 4'hF;
			else if (six && cnt == 8'd3) low = 4'h0;
			else                         low = {2'b00, rel[1], rel[0]};
			v = {2'b00, rel[7], rel[4], low};
		end
		return v;
	endfunction

	always_comb begin
		read_data = '0;
		if (item.opcode == OP_READ) begin
			unique case (item.reg_word)
				W_VERSION: read_data = st.version_byte;
				W_P1_DATA: read_data = pad_byte(st.port_data[0][TH_POS],
					st.six_button_ports[0], st.th_edge_count[0], item.pad_buttons);
				W_P2_DATA: read_data = pad_byte(st.port_data[1][TH_POS],
					st.six_button_ports[1], st.th_edge_count[1], item.pad_buttons);
				W_EX_DATA: read_data = EXP_READ;
				W_P1_CTRL: read_data = st.port_ctrl[0];
				W_P2_CTRL: read_data = st.port_ctrl[1];
				W_EX_CTRL: read_data = st.port_ctrl[2];
				default:   read_data = '0;
			endcase
		end
	end

endmodule

/* src/six_button_pad_io_port_core.sv */
// A result reaches m_tvalid through the input register, then the result register.
// One item per cycle while m_tready does not stall the result register; these
// registers bracket the single pass of read selection and state update.
// Reset: arst_n clears both stage valids, the port state and the edge counters,
// and loads the version byte with 0x80 and the six-button select with zero.
// ----------------------------------------------------------------------------
// six_button_pad_io_port_core
// Two-port pad I/O block with TH-multiplexed reads and six-button counting.
// ----------------------------------------------------------------------------
module six_button_pad_io_port_core
	import sbpio_pkg::*;
(
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   s_tvalid,
	output logic                   s_tready,
	input  logic [IN_TDATA_W-1:0]  s_tdata,  // opcode, reg_word, write_data, pad_buttons
	output logic                   m_tvalid,
	input  logic                   m_tready,
	output logic [OUT_TDATA_W-1:0] m_tdata,  // read_data
	input  logic                   cfg_we,
	input  logic                   cfg_index,
	input  logic [7:0]             cfg_data
);

	item_t       item_s1;
	logic        valid_s1;
	logic [7:0]  data_s2;
	logic        valid_s2;
	logic        advance;
	logic        accept;
	logic [7:0]  read_data;
	port_state_t st;

	assign advance  = !valid_s2 || m_tready;
	assign s_tready = !valid_s1 || advance;
	assign accept   = s_tvalid && s_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) item_s1 <= s_tdata[$bits(item_t)-1:0];
	end

	sbpio_state u_state (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data),
		.upd_en   (valid_s1 && advance),
		.upd_item (item_s1),
		.st       (st)
	);

	sbpio_read u_read (
		.st       (st),
		.item     (item_s1),
		.read_data(read_data)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && valid_s1) data_s2 <= read_data;
	end

	assign m_tvalid = valid_s2;
	assign m_tdata  = data_s2;

`ifndef SYNTHESIS
	a_nonread_zero: assert property (@(posedge clk) disable iff (!arst_n)
		advance && valid_s1 && (item_s1.opcode != OP_READ) |=> m_tdata == 8'h00)
		else $error("write or timeout produced nonzero read data");

	a_exp_read: assert property (@(posedge clk) disable iff (!arst_n)
		advance && valid_s1 && (item_s1.opcode == OP_READ) &&
		(item_s1.reg_word == W_EX_DATA) |=> m_tdata == EXP_READ)
		else $error("expansion data read not 0xFF");
`endif

endmodule
